>>> rtl/cmf_pkg.sv
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared constants, status codes and types of the coalescing message FIFO.
// ----------------------------------------------------------------------------
package cmf_pkg;

    localparam int DEPTH       = 16;
    localparam int MSG_W       = 32;
    localparam int COUNT_W     = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int STATUS_W    = 3;
    localparam int CAP_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = CAP_W;
    localparam int OUT_RAW_W   = STATUS_W + MSG_W + OCC_W;
    localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DISABLED = 3'd1,
        ST_FULL     = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic {
        OP_SEND    = 1'b0,
        OP_RECEIVE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 1'b0,
        CFG_CAPACITY = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [OCC_W-1:0] entries_used;
        logic [MSG_W-1:0] message_out;
        t_status          status;
    } t_result;

    typedef struct packed {
        logic               msg_we;
        logic               cnt_we;
        logic [IDX_W-1:0]   addr;
        logic [MSG_W-1:0]   msg;
        logic [COUNT_W-1:0] cnt;
    } t_store_wr;

endpackage

>>> rtl/cmf_store.sv
// ----------------------------------------------------------------------------
// cmf_store
// Entry and repeat-count storage: one write port, one combinational read port.
// ----------------------------------------------------------------------------
module cmf_store
    import cmf_pkg::*;
(
    input  logic               i_clk,
    input  t_store_wr          i_wr,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output logic [MSG_W-1:0]   o_rd_msg,
    output logic [COUNT_W-1:0] o_rd_cnt
);

    logic [MSG_W-1:0]   r_msg [DEPTH];
    logic [COUNT_W-1:0] r_cnt [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.msg_we) begin
            r_msg[i_wr.addr] <= i_wr.msg;
        end
        if (i_wr.cnt_we) begin
            r_cnt[i_wr.addr] <= i_wr.cnt;
        end
    end

    assign o_rd_msg = r_msg[i_rd_addr];
    assign o_rd_cnt = r_cnt[i_rd_addr];

endmodule

>>> rtl/cmf_ctrl.sv
// ----------------------------------------------------------------------------
// cmf_ctrl
// Queue pointers, occupancy and the per-operation send/receive decision.
// ----------------------------------------------------------------------------
module cmf_ctrl
    import cmf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_op                i_op,
    input  logic [MSG_W-1:0]   i_msg,
    input  logic               i_enabled,
    input  logic [CAP_W-1:0]   i_capacity,
    input  logic [MSG_W-1:0]   i_rd_msg,
    input  logic [COUNT_W-1:0] i_rd_cnt,
    output logic [IDX_W-1:0]   o_rd_addr,
    output t_store_wr          o_wr,
    output t_result            o_result
);

    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_tail, n_tail;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic [IDX_W-1:0]   prev_tail;
    logic [IDX_W-1:0]   next_tail;
    logic [IDX_W-1:0]   next_head;
    logic [OCC_W-1:0]   eff_cap;
    logic [COUNT_W-1:0] cnt_inc;
    t_store_wr          wr;
    t_status            status;
    logic [MSG_W-1:0]   rd_msg;

    assign prev_tail = (r_tail == '0) ? LAST_SLOT : r_tail - 1'b1;
    assign next_tail = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
    assign next_head = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign o_rd_addr = (i_op == OP_RECEIVE) ? r_head : prev_tail;
    assign cnt_inc   = i_rd_cnt + 1'b1;

    always_comb begin
        if (i_capacity == '0) begin
            eff_cap = OCC_W'(1);
        end else if (OCC_W'(i_capacity) > DEPTH_OCC) begin
            eff_cap = DEPTH_OCC;
        end else begin
            eff_cap = OCC_W'(i_capacity);
        end
    end

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        status = ST_OK;
        rd_msg = '0;
        wr     = '{msg_we: 1'b0, cnt_we: 1'b0, addr: o_rd_addr, msg: i_msg, cnt: cnt_inc};
        if (!i_enabled) begin
            status = ST_DISABLED;
        end else if (i_op == OP_SEND) begin
            if (r_occ != '0 && i_rd_msg == i_msg) begin
                if (cnt_inc == '0) begin
                    status = ST_OVERFLOW;
                end else begin
                    wr.cnt_we = 1'b1;
                end
            end else if (r_occ != '0 && r_occ >= eff_cap) begin
                status = ST_FULL;
            end else begin
                wr.msg_we = 1'b1;
                wr.cnt_we = 1'b1;
                wr.addr   = r_tail;
                wr.cnt    = COUNT_W'(1);
                n_tail    = next_tail;
                n_occ     = r_occ + 1'b1;
            end
        end else begin
            if (r_occ == '0) begin
                status = ST_EMPTY;
            end else begin
                rd_msg = i_rd_msg;
                if (i_rd_cnt > COUNT_W'(1)) begin
                    wr.cnt_we = 1'b1;
                    wr.cnt    = i_rd_cnt - 1'b1;
                end else begin
                    n_head = next_head;
                    n_occ  = r_occ - 1'b1;
                    if (n_occ == '0) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                end
            end
        end
        wr.msg_we = wr.msg_we & i_fire;
        wr.cnt_we = wr.cnt_we & i_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else if (i_fire) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

    assign o_wr     = wr;
    assign o_result = '{entries_used: n_occ, message_out: rd_msg, status: status};

endmodule

>>> rtl/coalescing_message_fifo_core.sv
// ----------------------------------------------------------------------------
// coalescing_message_fifo_core
// Message FIFO that folds a send equal to the newest entry into its repeat count.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input waits in the input register, and its result is then
// captured in the result register. Throughput: one operation per cycle, set by the
// read-modify-write of the head or newest slot; a stalled result holds the input.
// Reset (synchronous, active low): queue empty, pointers zero, enabled, capacity
// 16; stored entries are not cleared and need no clearing time.
// ----------------------------------------------------------------------------
module coalescing_message_fifo_core
    import cmf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [MSG_W-1:0]      s_axis_tdata,   // message_in
    input  logic                  s_axis_tuser,   // op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // status, message_out, entries_used
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_enabled;
    logic [CAP_W-1:0]   r_capacity;
    logic               r_in_valid;
    t_op                r_in_op;
    logic [MSG_W-1:0]   r_in_msg;
    logic               r_out_valid;
    t_result            r_out;
    logic               fire;
    logic [IDX_W-1:0]   rd_addr;
    logic [MSG_W-1:0]   rd_msg;
    logic [COUNT_W-1:0] rd_cnt;
    t_store_wr          wr;
    t_result            result;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b1;
            r_capacity <= CAP_W'(DEPTH);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ENABLE:   r_enabled  <= i_cfg_data[0];
                CFG_CAPACITY: r_capacity <= i_cfg_data[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op  <= t_op'(s_axis_tuser);
            r_in_msg <= s_axis_tdata;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    cmf_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_msg  (rd_msg),
        .o_rd_cnt  (rd_cnt)
    );

    cmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_op       (r_in_op),
        .i_msg      (r_in_msg),
        .i_enabled  (r_enabled),
        .i_capacity (r_capacity),
        .i_rd_msg   (rd_msg),
        .i_rd_cnt   (rd_cnt),
        .o_rd_addr  (rd_addr),
        .o_wr       (wr),
        .o_result   (result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out);

endmodule

>>> rtl/cmf_checker.sv
// ----------------------------------------------------------------------------
// cmf_checker
// Port-level checks of the coalescing message FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module cmf_checker
    import cmf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_result res;
    assign res = t_result'(m_axis_tdata[OUT_RAW_W-1:0]);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.status == ST_OK || res.status == ST_DISABLED ||
                           res.status == ST_FULL || res.status == ST_OVERFLOW ||
                           res.status == ST_EMPTY))
        else $error("status out of range");

    a_msg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.status != ST_OK |-> res.message_out == '0)
        else $error("message on failed operation");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> res.entries_used <= DEPTH_OCC)
        else $error("occupancy above depth");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind coalescing_message_fifo_core cmf_checker u_cmf_checker (.*);
